@@ src/time_of_day_clock_with_alarms_defines.svh @@
// Assertion macros for the time-of-day clock.
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARMS_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARMS_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the cycle after the antecedent.
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("time of day clock: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("time of day clock: same-cycle check failed");

`else

`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define TDC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/tdc_pkg.sv @@
// Shared constants and widths for the time-of-day clock.
`timescale 1ns / 1ps

package tdc_pkg;

    localparam int NUM_ALARMS = 3;
    localparam int ALARM_REGS = 3;
    localparam int MASK_W     = 3;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int PRE_W   = 8;
    localparam int CFG_W   = 12;
    localparam int REG_IDX_W = 2;

    localparam logic [PRE_W-1:0]  PRESCALE_RESET = 8'h09;
    localparam logic [SEC_W-1:0]  LAST_SECOND    = 6'd59;
    localparam logic [MIN_W-1:0]  LAST_MINUTE    = 6'd59;
    localparam logic [HOUR_W-1:0] LAST_HOUR      = 5'd23;
    localparam logic [HOUR_W-1:0] HOURS_PER_DAY  = 5'd24;
    localparam logic [MIN_W-1:0]  MINS_PER_HOUR  = 6'd60;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_TICKS      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALARM_BASE = 2'd1;

    // Alarm setting layout
    localparam int ALARM_EN_BIT = 11;
    localparam int ALARM_HR_LSB = 6;
    localparam int ALARM_MN_LSB = 0;

    // Command codes
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_TIME = 1'b1;

endpackage

@@ src/tdc_ifs.sv @@
// Request and result channel interfaces for the time-of-day clock.
`timescale 1ns / 1ps

interface tdc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [tdc_pkg::HOUR_W-1:0]  new_hours;
    logic [tdc_pkg::MIN_W-1:0]   new_minutes;

    modport source (output valid, output opcode, output new_hours, output new_minutes,
                    input ready);
    modport sink   (input valid, input opcode, input new_hours, input new_minutes,
                    output ready);
endinterface

interface tdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [tdc_pkg::HOUR_W-1:0]  hours_now;
    logic [tdc_pkg::MIN_W-1:0]   minutes_now;
    logic [tdc_pkg::SEC_W-1:0]   seconds_now;
    logic [tdc_pkg::MASK_W-1:0]  fired_mask;
    logic                        alarm_fired;
    logic                        minute_rolled;

    modport source (output valid, output hours_now, output minutes_now, output seconds_now,
                    output fired_mask, output alarm_fired, output minute_rolled,
                    input ready);
    modport sink   (input valid, input hours_now, input minutes_now, input seconds_now,
                    input fired_mask, input alarm_fired, input minute_rolled,
                    output ready);
endinterface

@@ src/time_of_day_clock_with_alarms.sv @@
// Time-of-day clock with three alarms: top level.
`timescale 1ns / 1ps
`include "time_of_day_clock_with_alarms_defines.svh"

// Each request (a tick or a set-time) updates the hours:minutes:seconds
// counters, a tick also the prescaler, and runs one alarm action, alternating
// between checking for matches and re-arming alarms whose time has passed.
// One request is taken every cycle; its result appears in the output register
// on the following cycle and the next request is accepted while that result
// waits, as long as the result is being taken. The rate is set by the
// update loop through the time and alarm state registers. The user must
// write alarm and prescaler registers through the configuration port only
// while no request is in flight; the block itself does not enforce this.
module time_of_day_clock_with_alarms (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tdc_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [tdc_pkg::CFG_W-1:0]       cfg_data,
    tdc_in_if.sink                          cmd,
    tdc_out_if.source                       result
);

    logic [tdc_pkg::PRE_W-1:0]  ticks_reg;
    logic [tdc_pkg::CFG_W-1:0]  alarm_setting_reg [tdc_pkg::NUM_ALARMS];

    logic [tdc_pkg::PRE_W-1:0]  prescale_reg, prescale_next;
    logic [tdc_pkg::SEC_W-1:0]  second_reg, second_next;
    logic [tdc_pkg::MIN_W-1:0]  minute_reg, minute_next;
    logic [tdc_pkg::HOUR_W-1:0] hour_reg, hour_next;
    logic [tdc_pkg::NUM_ALARMS-1:0] done_reg, done_next;
    logic                       rearm_phase_reg;

    logic [tdc_pkg::NUM_ALARMS-1:0] fire;
    logic [tdc_pkg::MASK_W-1:0] mask_next;
    logic                       rolled_next;

    logic                       out_valid_reg;
    logic [tdc_pkg::HOUR_W-1:0] hours_now_reg;
    logic [tdc_pkg::MIN_W-1:0]  minutes_now_reg;
    logic [tdc_pkg::SEC_W-1:0]  seconds_now_reg;
    logic [tdc_pkg::MASK_W-1:0] fired_mask_reg;
    logic                       alarm_fired_reg;
    logic                       minute_rolled_reg;

    logic                       cmd_fire;

    assign cmd.ready = !out_valid_reg || result.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Time update
    always_comb
    begin
        prescale_next = prescale_reg;
        second_next   = second_reg;
        minute_next   = minute_reg;
        hour_next     = hour_reg;
        rolled_next   = 1'b0;
        if (cmd.opcode == tdc_pkg::OP_SET_TIME)
        begin
            hour_next   = (cmd.new_hours >= tdc_pkg::HOURS_PER_DAY) ?
                          tdc_pkg::LAST_HOUR : cmd.new_hours;
            minute_next = (cmd.new_minutes >= tdc_pkg::MINS_PER_HOUR) ?
                          tdc_pkg::LAST_MINUTE : cmd.new_minutes;
            second_next = '0;
        end
        else if (prescale_reg != '0)
        begin
            prescale_next = prescale_reg - 1'b1;
        end
        else
        begin
            prescale_next = ticks_reg;
            if (second_reg == tdc_pkg::LAST_SECOND)
            begin
                second_next = '0;
                rolled_next = 1'b1;
                if (minute_reg == tdc_pkg::LAST_MINUTE)
                begin
                    minute_next = '0;
                    hour_next   = (hour_reg == tdc_pkg::LAST_HOUR) ? '0 : hour_reg + 1'b1;
                end
                else
                begin
                    minute_next = minute_reg + 1'b1;
                end
            end
            else
            begin
                second_next = second_reg + 1'b1;
            end
        end
    end

    // Alarm action against the updated time
    always_comb
    begin
        logic match;
        logic [tdc_pkg::HOUR_W-1:0] a_hour;
        logic [tdc_pkg::MIN_W-1:0]  a_min;
        mask_next = '0;
        for (int i = 0; i < tdc_pkg::NUM_ALARMS; i++)
        begin
            a_hour = alarm_setting_reg[i][tdc_pkg::ALARM_HR_LSB +: tdc_pkg::HOUR_W];
            a_min  = alarm_setting_reg[i][tdc_pkg::ALARM_MN_LSB +: tdc_pkg::MIN_W];
            match  = (a_hour == hour_next) && (a_min == minute_next);
            if (!rearm_phase_reg)
            begin
                fire[i]      = alarm_setting_reg[i][tdc_pkg::ALARM_EN_BIT] && !done_reg[i]
                               && match;
                done_next[i] = done_reg[i] || fire[i];
            end
            else
            begin
                fire[i]      = 1'b0;
                done_next[i] = done_reg[i] && match;
            end
            if (i < tdc_pkg::MASK_W)
                mask_next[i] = fire[i];
        end
    end

    // Configuration registers; alarms without a register stay zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= tdc_pkg::PRESCALE_RESET;
            for (int i = 0; i < tdc_pkg::NUM_ALARMS; i++)
                alarm_setting_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tdc_pkg::REG_TICKS)
                ticks_reg <= cfg_data[tdc_pkg::PRE_W-1:0];
            for (int i = 0; i < tdc_pkg::NUM_ALARMS; i++)
            begin
                if (i < tdc_pkg::ALARM_REGS &&
                    cfg_index == tdc_pkg::REG_ALARM_BASE + tdc_pkg::REG_IDX_W'(i))
                    alarm_setting_reg[i] <= cfg_data;
            end
        end
    end

    // Clock and alarm state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg    <= tdc_pkg::PRESCALE_RESET;
            second_reg      <= '0;
            minute_reg      <= '0;
            hour_reg        <= '0;
            done_reg        <= '0;
            rearm_phase_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            prescale_reg    <= prescale_next;
            second_reg      <= second_next;
            minute_reg      <= minute_next;
            hour_reg        <= hour_next;
            done_reg        <= done_next;
            rearm_phase_reg <= !rearm_phase_reg;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            hours_now_reg     <= hour_next;
            minutes_now_reg   <= minute_next;
            seconds_now_reg   <= second_next;
            fired_mask_reg    <= mask_next;
            alarm_fired_reg   <= |fire;
            minute_rolled_reg <= rolled_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.hours_now     = hours_now_reg;
    assign result.minutes_now   = minutes_now_reg;
    assign result.seconds_now   = seconds_now_reg;
    assign result.fired_mask    = fired_mask_reg;
    assign result.alarm_fired   = alarm_fired_reg;
    assign result.minute_rolled = minute_rolled_reg;

    `TDC_ASSERT_NEXT(a_rearm_never_fires, clk, rst_n, cmd_fire && rearm_phase_reg, fired_mask_reg == '0 && !alarm_fired_reg)
    `TDC_ASSERT_NEXT(a_phase_flips, clk, rst_n, cmd_fire, rearm_phase_reg != $past(rearm_phase_reg))
    `TDC_ASSERT_SAME(a_roll_zero_seconds, clk, rst_n, out_valid_reg && minute_rolled_reg, seconds_now_reg == '0)
    `TDC_ASSERT_NEXT(a_fired_marked_done, clk, rst_n, cmd_fire && (|fire), (done_reg & $past(fire)) == $past(fire))

endmodule

@@ verif/tdc_clock_checker.sv @@
// Scoreboard for the time-of-day clock: predicts each result and compares it.
`timescale 1ns / 1ps

module tdc_clock_checker
    import tdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tdc_in_if                    cmd,
    tdc_out_if                   result,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic [MASK_W-1:0] fired;
        logic              any_fired;
        logic              rolled;
    } clock_reading_t;

    logic [PRE_W-1:0]     reload_q;
    logic [CFG_W-1:0]     alarm_cfg [NUM_ALARMS];
    logic [PRE_W-1:0]     prescale_q;
    logic [SEC_W-1:0]     second_q;
    logic [MIN_W-1:0]     minute_q;
    logic [HOUR_W-1:0]    hour_q;
    logic                 alarm_done [NUM_ALARMS];
    logic                 rearm_phase;
    logic [REG_IDX_W-1:0] slot;

    clock_reading_t due_readings [$];
    clock_reading_t want;

    // Update the time first, then run the alarm action of this phase on the new time
    function automatic clock_reading_t advance_clock(input logic op,
                                                     input logic [HOUR_W-1:0] h,
                                                     input logic [MIN_W-1:0] m);
        clock_reading_t r;
        logic           hit;
        r = '0;
        if (op == OP_SET_TIME) begin
            hour_q   = (h > LAST_HOUR) ? LAST_HOUR : h;
            minute_q = (m > LAST_MINUTE) ? LAST_MINUTE : m;
            second_q = '0;
        end
        else if (prescale_q != '0) begin
            prescale_q = prescale_q - 1'b1;
        end
        else begin
            prescale_q = reload_q;
            if (second_q == LAST_SECOND) begin
                second_q = '0;
                r.rolled = 1'b1;
                if (minute_q == LAST_MINUTE) begin
                    minute_q = '0;
                    hour_q   = (hour_q == LAST_HOUR) ? '0 : hour_q + 1'b1;
                end
                else begin
                    minute_q = minute_q + 1'b1;
                end
            end
            else begin
                second_q = second_q + 1'b1;
            end
        end

        for (int i = 0; i < NUM_ALARMS; i++) begin
            hit = (alarm_cfg[i][ALARM_HR_LSB +: HOUR_W] == hour_q) &&
                  (alarm_cfg[i][ALARM_MN_LSB +: MIN_W] == minute_q);
            if (!rearm_phase) begin
                if (alarm_cfg[i][ALARM_EN_BIT] && !alarm_done[i] && hit) begin
                    alarm_done[i] = 1'b1;
                    r.any_fired   = 1'b1;
                    if (i < MASK_W)
                        r.fired[i] = 1'b1;
                end
            end
            else if (alarm_done[i] && !hit) begin
                alarm_done[i] = 1'b0;
            end
        end
        rearm_phase = !rearm_phase;

        r.hours   = hour_q;
        r.minutes = minute_q;
        r.seconds = second_q;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n) begin
            reload_q    = PRESCALE_RESET;
            prescale_q  = PRESCALE_RESET;
            second_q    = '0;
            minute_q    = '0;
            hour_q      = '0;
            rearm_phase = 1'b0;
            for (int i = 0; i < NUM_ALARMS; i++) begin
                alarm_cfg[i]  = '0;
                alarm_done[i] = 1'b0;
            end
            due_readings.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_TICKS) begin
                    reload_q = cfg_data[PRE_W-1:0];
                end
                else begin
                    slot = cfg_index - REG_ALARM_BASE;
                    if (int'(slot) < NUM_ALARMS)
                        alarm_cfg[slot] = cfg_data;
                end
            end

            if (result.valid && result.ready) begin
                if (due_readings.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end
                else begin
                    want = due_readings.pop_front();
                    if (result.hours_now !== want.hours)
                        report_mismatch($sformatf("hours_now %0d, expected %0d",
                                                  result.hours_now, want.hours));
                    if (result.minutes_now !== want.minutes)
                        report_mismatch($sformatf("minutes_now %0d, expected %0d",
                                                  result.minutes_now, want.minutes));
                    if (result.seconds_now !== want.seconds)
                        report_mismatch($sformatf("seconds_now %0d, expected %0d",
                                                  result.seconds_now, want.seconds));
                    if (result.fired_mask !== want.fired)
                        report_mismatch($sformatf("fired_mask %b, expected %b",
                                                  result.fired_mask, want.fired));
                    if (result.alarm_fired !== want.any_fired)
                        report_mismatch($sformatf("alarm_fired %b, expected %b",
                                                  result.alarm_fired, want.any_fired));
                    if (result.minute_rolled !== want.rolled)
                        report_mismatch($sformatf("minute_rolled %b, expected %b",
                                                  result.minute_rolled, want.rolled));
                end
            end

            if (cmd.valid && cmd.ready)
                due_readings.push_back(advance_clock(cmd.opcode, cmd.new_hours,
                                                     cmd.new_minutes));
        end
        pending = due_readings.size();
    end

endmodule

@@ verif/tb_time_of_day_clock_with_alarms.sv @@
// Testbench top for the time-of-day clock: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_time_of_day_clock_with_alarms;
    import tdc_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_REQUESTS  = 96;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tdc_in_if  cmd_if ();
    tdc_out_if res_if ();

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int hold_token;
    int hold_seen;
    int hold_left;
    int quiet_cycles;
    int sent;

    logic [PRE_W-1:0] reload_now;
    logic [CFG_W-1:0] alarm_now [ALARM_REGS];

    time_of_day_clock_with_alarms u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .result    (res_if)
    );

    tdc_clock_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd_if),
        .result     (res_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: a requested hold-off is counted out here, otherwise stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_OFF_CYCLES;
            res_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_request(input logic op, input logic [HOUR_W-1:0] h,
                               input logic [MIN_W-1:0] m);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= op;
        cmd_if.new_hours   <= h;
        cmd_if.new_minutes <= m;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        sent++;
    endtask

    // Tick fields carry random junk: the block must ignore them
    task automatic tick_run(input int n);
        repeat (n)
            put_request(OP_TICK, HOUR_W'($urandom_range(0, 31)), MIN_W'($urandom_range(0, 63)));
    endtask

    // Hold the request side until every result has come back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic load_config();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TICKS;
        cfg_data  <= CFG_W'(reload_now);
        @(posedge clk);
        for (int i = 0; i < ALARM_REGS; i++)
        begin
            cfg_index <= REG_ALARM_BASE + REG_IDX_W'(i);
            cfg_data  <= alarm_now[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int               p;
        int               a;
        int               kind;
        int               phase_end;
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0]  m;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.opcode      = OP_TICK;
        cmd_if.new_hours   = '0;
        cmd_if.new_minutes = '0;
        idle_pct           = 0;
        stall_pct          = 0;
        hold_token         = 0;
        sent               = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Prescaler and time straight out of reset; an even count leaves the check action next
        tick_run(4);
        drain();

        // Alarms at the end of the day, at midnight, and one disabled at midday
        reload_now   = '0;
        alarm_now[0] = '0;
        alarm_now[0][ALARM_EN_BIT] = 1'b1;
        alarm_now[0][ALARM_HR_LSB +: HOUR_W] = LAST_HOUR;
        alarm_now[0][ALARM_MN_LSB +: MIN_W]  = LAST_MINUTE;
        alarm_now[1] = '0;
        alarm_now[1][ALARM_EN_BIT] = 1'b1;
        alarm_now[2] = '0;
        alarm_now[2][ALARM_HR_LSB +: HOUR_W] = 5'd12;
        alarm_now[2][ALARM_MN_LSB +: MIN_W]  = 6'd30;
        load_config();

        put_request(OP_SET_TIME, '1, '1);        // clamps to 23:59, alarm 0 fires
        put_request(OP_TICK, '1, '1);
        put_request(OP_TICK, '0, '0);            // already done, stays quiet
        put_request(OP_SET_TIME, '0, '0);        // re-arm clears alarm 0
        put_request(OP_TICK, '0, '0);            // alarm 1 fires
        put_request(OP_SET_TIME, 5'd24, 6'd60);
        put_request(OP_TICK, 5'd10, 6'd21);      // alarm 0 fires again
        put_request(OP_SET_TIME, 5'd12, 6'd30);
        put_request(OP_TICK, 5'd21, 6'd42);      // disabled alarm matches but stays quiet
        put_request(OP_SET_TIME, LAST_HOUR, LAST_MINUTE);
        put_request(OP_SET_TIME, '0, '0);
        put_request(OP_SET_TIME, 5'd16, 6'd32);
        put_request(OP_SET_TIME, 5'd15, 6'd31);
        tick_run(7);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                3:       reload_now = '1;
                7:       reload_now = PRE_W'(1);
                10:      reload_now = PRE_W'($urandom_range(0, 255));
                default: reload_now = PRE_W'($urandom_range(0, 1));
            endcase
            for (a = 0; a < ALARM_REGS; a++)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    alarm_now[a] = CFG_W'($urandom_range(0, 4095));
                end
                else
                begin
                    alarm_now[a] = '0;
                    alarm_now[a][ALARM_EN_BIT] = (kind != 1);
                    alarm_now[a][ALARM_HR_LSB +: HOUR_W] = HOUR_W'($urandom_range(0, 23));
                    alarm_now[a][ALARM_MN_LSB +: MIN_W]  = MIN_W'($urandom_range(0, 59));
                end
                // Share a time now and then so several alarms fire together
                if (a > 0 && $urandom_range(0, 3) == 0)
                    alarm_now[a] = alarm_now[0];
            end
            load_config();

            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct  = 26;
                    stall_pct = 26;
                end
            endcase
            // Long hold-off on the result side while requests keep coming
            if (p == 4)
                hold_token++;

            phase_end = sent + PHASE_REQUESTS;
            while (sent < phase_end)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                begin
                    // Set the clock on an alarm time, or a minute short of it, then tick
                    a = $urandom_range(0, ALARM_REGS - 1);
                    h = alarm_now[a][ALARM_HR_LSB +: HOUR_W];
                    m = alarm_now[a][ALARM_MN_LSB +: MIN_W];
                    if (h > LAST_HOUR)
                        h = LAST_HOUR;
                    if (m > LAST_MINUTE)
                        m = LAST_MINUTE;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        if (m == '0)
                        begin
                            m = LAST_MINUTE;
                            h = (h == '0) ? LAST_HOUR : h - 1'b1;
                        end
                        else
                        begin
                            m = m - 1'b1;
                        end
                    end
                    put_request(OP_SET_TIME, h, m);
                    tick_run($urandom_range(1, 130));
                end
                else if (kind == 6)
                begin
                    // Run across midnight
                    put_request(OP_SET_TIME, LAST_HOUR, LAST_MINUTE);
                    tick_run($urandom_range(50, 130));
                end
                else if (kind == 7)
                begin
                    repeat ($urandom_range(3, 10))
                        put_request(($urandom_range(0, 1) == 1) ? OP_SET_TIME : OP_TICK,
                                    HOUR_W'($urandom_range(0, 31)),
                                    MIN_W'($urandom_range(0, 63)));
                end
                else
                begin
                    tick_run($urandom_range(1, 40));
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
